>>> src/diff_drive_pose_integrator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pose integrator
// Shared property wrappers that sample on i_clk and are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_POSE_INTEGRATOR_DEFINES_SVH
`define DIFF_DRIVE_POSE_INTEGRATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDPI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ddpi_pkg.sv
// ----------------------------------------------------------------------------
// ddpi_pkg
// Widths, constants, codes and types shared by the pose integrator modules.
// ----------------------------------------------------------------------------
package ddpi_pkg;

    // Position word width and heading angle width.
    localparam int POS_BITS   = 32;
    localparam int ANGLE_BITS = 16;

    // Field widths of the streams and registers.
    localparam int SPEED_W    = 24;
    localparam int STEP_T_W   = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int HEAD_OUT_W = 16;
    localparam int POS_OUT_W  = 32;

    localparam logic [STEP_T_W-1:0] STEP_TIME_RESET = 16'd2621;

    // CORDIC: Q2.30 vectors, angle in units of 2^-32 turn, one guard bit.
    localparam int CORDIC_N     = 16;
    localparam int CORDIC_IDX_W = $clog2(CORDIC_N);
    localparam int CORDIC_W     = 33;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0    = 33'sd652032874;
    localparam logic signed [CORDIC_W-1:0] TURN_QUARTER = 33'sd1073741824;
    localparam logic signed [CORDIC_W-1:0] TURN_HALF    = 33'sd2147483648;
    localparam int TRIG_SH = 8;
    localparam int TRIG_W  = 25;

    // Serial multiplier operand and product widths.
    localparam int MUL_A_W = SPEED_W + STEP_T_W;
    localparam int MUL_B_W = TRIG_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // 1/(2 pi) in Q24.
    localparam logic [MUL_B_W-1:0] INV_TWO_PI_Q24 = 25'd2670177;

    // Position step: Q54 product rounded to Q16.
    localparam int STEP_SH = 38;
    localparam int STEP_W  = 26;
    localparam int SUM_W   = ((POS_BITS > STEP_W) ? POS_BITS : STEP_W) + 1;
    localparam int POS_LD_W  = (POS_BITS > CFG_DATA_W) ? POS_BITS : CFG_DATA_W;
    localparam int POS_EXT_W = (POS_BITS > POS_OUT_W) ? POS_BITS : POS_OUT_W;

    // Heading step: Q56 turns rounded to ANGLE_BITS.
    localparam int HEAD_PROD_W = 56;
    localparam int DH_SH       = HEAD_PROD_W - ANGLE_BITS;
    localparam int HEAD_EXT_W  = (ANGLE_BITS > HEAD_OUT_W) ? ANGLE_BITS : HEAD_OUT_W;

    // Input item kinds.
    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_TIME     = 8'd0,
        CFG_START_X       = 8'd1,
        CFG_START_Y       = 8'd2,
        CFG_START_HEADING = 8'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE_A,
        ST_PHASE_B,
        ST_ROUND,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [CORDIC_W-1:0] atan_turns(
        input logic [CORDIC_IDX_W-1:0] i
    );
        logic signed [CORDIC_W-1:0] v;
        unique case (i)
            4'd0:    v = 33'sd536870912;
            4'd1:    v = 33'sd316933406;
            4'd2:    v = 33'sd167458907;
            4'd3:    v = 33'sd85004756;
            4'd4:    v = 33'sd42667331;
            4'd5:    v = 33'sd21354465;
            4'd6:    v = 33'sd10679838;
            4'd7:    v = 33'sd5340245;
            4'd8:    v = 33'sd2670163;
            4'd9:    v = 33'sd1335087;
            4'd10:   v = 33'sd667544;
            4'd11:   v = 33'sd333772;
            4'd12:   v = 33'sd166886;
            4'd13:   v = 33'sd83443;
            4'd14:   v = 33'sd41722;
            4'd15:   v = 33'sd20861;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> src/ddpi_serial_mul.sv
// ----------------------------------------------------------------------------
// ddpi_serial_mul
// Signed shift-add multiplier that consumes one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddpi_serial_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [ddpi_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [ddpi_pkg::MUL_B_W-1:0]  i_b,
    output ddpi_pkg::t_unit_stat                 o_stat,
    output logic        [ddpi_pkg::MUL_P_W-1:0]  o_prod
);
    import ddpi_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic signed [MUL_A_W-1:0] r_a;
    logic signed [MUL_A_W:0]   r_hi;
    logic        [MUL_B_W-1:0] r_lo;
    logic        [CNT_W-1:0]   r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic                      w_last;
    logic signed [MUL_A_W+1:0] w_a_ext;
    logic signed [MUL_A_W+1:0] w_add;
    logic signed [MUL_A_W+1:0] w_sum;

    // The sign bit of the multiplier carries negative weight, so the last
    // partial product is subtracted.
    always_comb begin
        w_last  = (r_cnt == CNT_W'(MUL_B_W - 1));
        w_a_ext = (MUL_A_W + 2)'(r_a);
        if (!r_lo[0]) begin
            w_add = '0;
        end else if (w_last) begin
            w_add = -w_a_ext;
        end else begin
            w_add = w_a_ext;
        end
        w_sum = (MUL_A_W + 2)'(r_hi) + w_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && w_last;
            if (i_start) begin
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= w_sum[MUL_A_W+1:1];
                r_lo  <= {w_sum[0], r_lo[MUL_B_W-1:1]};
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_prod = {r_hi[MUL_A_W-1:0], r_lo};

endmodule

>>> src/ddpi_cordic.sv
// ----------------------------------------------------------------------------
// ddpi_cordic
// Iterative rotation-mode CORDIC giving cos and sin of a binary angle.
// ----------------------------------------------------------------------------
module ddpi_cordic (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic        [ddpi_pkg::ANGLE_BITS-1:0] i_heading,
    output ddpi_pkg::t_unit_stat                   o_stat,
    output logic signed [ddpi_pkg::TRIG_W-1:0]     o_cos,
    output logic signed [ddpi_pkg::TRIG_W-1:0]     o_sin
);
    import ddpi_pkg::*;

    localparam int IT_W = $clog2(CORDIC_N + 1);

    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [CORDIC_W-1:0] r_z;
    logic                       r_neg;
    logic        [IT_W-1:0]     r_it;
    logic                       r_busy;
    logic                       r_done;

    logic        [31:0]         w_z32;
    logic signed [CORDIC_W-1:0] w_z0;
    logic signed [CORDIC_W-1:0] w_zf;
    logic                       w_negf;
    logic signed [CORDIC_W-1:0] w_xs;
    logic signed [CORDIC_W-1:0] w_ys;
    logic signed [CORDIC_W-1:0] w_atan;
    logic signed [CORDIC_W-1:0] w_c;
    logic signed [CORDIC_W-1:0] w_s;
    logic signed [CORDIC_W:0]   w_cr;
    logic signed [CORDIC_W:0]   w_sr;

    // Fold the angle into the right half plane; the far half is handled by
    // negating both results at the end.
    always_comb begin
        w_z32 = 32'(i_heading) << (32 - ANGLE_BITS);
        w_z0  = $signed({w_z32[31], w_z32});
        w_zf   = w_z0;
        w_negf = 1'b0;
        if (w_z0 > TURN_QUARTER) begin
            w_zf   = w_z0 - TURN_HALF;
            w_negf = 1'b1;
        end else if (w_z0 < -TURN_QUARTER) begin
            w_zf   = w_z0 + TURN_HALF;
            w_negf = 1'b1;
        end
    end

    always_comb begin
        w_xs   = r_x >>> r_it[CORDIC_IDX_W-1:0];
        w_ys   = r_y >>> r_it[CORDIC_IDX_W-1:0];
        w_atan = atan_turns(r_it[CORDIC_IDX_W-1:0]);
        w_c    = r_neg ? -r_x : r_x;
        w_s    = r_neg ? -r_y : r_y;
        w_cr   = (CORDIC_W + 1)'(w_c) + (CORDIC_W + 1)'(1 << (TRIG_SH - 1));
        w_sr   = (CORDIC_W + 1)'(w_s) + (CORDIC_W + 1)'(1 << (TRIG_SH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_it   <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_it == IT_W'(CORDIC_N));
            if (i_start) begin
                r_x    <= CORDIC_X0;
                r_y    <= '0;
                r_z    <= w_zf;
                r_neg  <= w_negf;
                r_it   <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_it != IT_W'(CORDIC_N)) begin
                    if (!r_z[CORDIC_W-1]) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_atan;
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_atan;
                    end
                    r_it <= r_it + IT_W'(1);
                end else begin
                    // Final pass: undo the fold and round to Q22.
                    o_cos  <= w_cr[TRIG_SH+TRIG_W-1:TRIG_SH];
                    o_sin  <= w_sr[TRIG_SH+TRIG_W-1:TRIG_SH];
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};

endmodule

>>> src/diff_drive_pose_integrator.sv
// ----------------------------------------------------------------------------
// diff_drive_pose_integrator
// Dead-reckoning pose integrator for a differential-drive robot.
// ----------------------------------------------------------------------------
// A command item is taken when idle and produces no result.
// A tick item gives one result; the next item can be taken once the block
// is idle again, while a result still waiting to be taken holds back the
// finish step of the next tick. A tick runs two serial multiplier rounds
// of 25 bits each. Reset (synchronous, active low) clears the pose and the
// commands and sets the step time to 1/25 s.
// ----------------------------------------------------------------------------
`include "diff_drive_pose_integrator_defines.svh"

module diff_drive_pose_integrator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    // Input items.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata, from bit 0 up: speed[23:0], turn_rate[47:24].
    input  logic [47:0]                           s_axis_tdata,
    // tuser, from bit 0 up: action[0].
    input  logic [0:0]                            s_axis_tuser,

    // Result items.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata, from bit 0 up: pos_x_out[31:0], pos_y_out[63:32],
    // heading_out[79:64], speed_out[103:80], turn_rate_out[127:104].
    output logic [127:0]                          m_axis_tdata,
    // tuser, from bit 0 up: saturated[0].
    output logic [0:0]                            m_axis_tuser,

    // Configuration writes.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ddpi_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ddpi_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import ddpi_pkg::*;

    // ------------------------------------------------------------------------
    // State and registers
    // ------------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic [STEP_T_W-1:0]   r_step_time;
    logic [POS_BITS-1:0]   r_pos_x;
    logic [POS_BITS-1:0]   r_pos_y;
    logic [ANGLE_BITS-1:0] r_heading;
    logic [SPEED_W-1:0]    r_cmd_speed;
    logic [SPEED_W-1:0]    r_cmd_turn;

    // Rounded per-tick increments, taken from the multiplier products.
    logic [STEP_W-1:0]     r_step_x;
    logic [STEP_W-1:0]     r_step_y;
    logic [ANGLE_BITS-1:0] r_dh;

    // Output register: holds a finished result until it is taken.
    logic                  r_m_valid;
    logic [POS_OUT_W-1:0]  r_out_x;
    logic [POS_OUT_W-1:0]  r_out_y;
    logic [HEAD_OUT_W-1:0] r_out_heading;
    logic [SPEED_W-1:0]    r_out_speed;
    logic [SPEED_W-1:0]    r_out_turn;
    logic                  r_out_sat;

    // ------------------------------------------------------------------------
    // Arithmetic units
    // ------------------------------------------------------------------------
    // Round one: the CORDIC resolves cos and sin of the old heading while
    // multiplier 0 forms speed * step_time and multiplier 2 forms
    // turn_rate * step_time. Round two: multipliers 0 and 1 scale the
    // velocity step by cos and sin, and multiplier 2 converts the angle step
    // from radians to turns.
    t_unit_stat                 cordic_stat;
    t_unit_stat                 mul0_stat;
    t_unit_stat                 mul1_stat;
    t_unit_stat                 mul2_stat;
    logic signed [TRIG_W-1:0]   w_cos;
    logic signed [TRIG_W-1:0]   w_sin;
    logic        [MUL_P_W-1:0]  w_prod0;
    logic        [MUL_P_W-1:0]  w_prod1;
    logic        [MUL_P_W-1:0]  w_prod2;
    logic signed [MUL_A_W-1:0]  w_mul0_a;
    logic signed [MUL_B_W-1:0]  w_mul0_b;
    logic signed [MUL_A_W-1:0]  w_mul2_a;
    logic signed [MUL_B_W-1:0]  w_mul2_b;
    logic                       w_start_a;
    logic                       w_start_b;
    logic                       w_finish;
    logic                       w_units_busy;
    logic                       w_in_accept;
    logic                       w_cfg_accept;

    assign w_units_busy = cordic_stat.busy | mul0_stat.busy | mul1_stat.busy
                          | mul2_stat.busy;

    // Operand selection for the two rounds. The round-two operands are the
    // round-one products, still held in the multipliers when they restart.
    always_comb begin
        if (w_start_b) begin
            w_mul0_a = $signed(w_prod0[MUL_A_W-1:0]);
            w_mul0_b = w_cos;
            w_mul2_a = $signed(w_prod2[MUL_A_W-1:0]);
            w_mul2_b = $signed(INV_TWO_PI_Q24);
        end else begin
            w_mul0_a = MUL_A_W'($signed(r_cmd_speed));
            w_mul0_b = $signed(MUL_B_W'(r_step_time));
            w_mul2_a = MUL_A_W'($signed(r_cmd_turn));
            w_mul2_b = $signed(MUL_B_W'(r_step_time));
        end
    end

    ddpi_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start_a),
        .i_heading (r_heading),
        .o_stat    (cordic_stat),
        .o_cos     (w_cos),
        .o_sin     (w_sin)
    );

    ddpi_serial_mul u_mul0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_a | w_start_b),
        .i_a     (w_mul0_a),
        .i_b     (w_mul0_b),
        .o_stat  (mul0_stat),
        .o_prod  (w_prod0)
    );

    ddpi_serial_mul u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_b),
        .i_a     ($signed(w_prod0[MUL_A_W-1:0])),
        .i_b     (w_sin),
        .o_stat  (mul1_stat),
        .o_prod  (w_prod1)
    );

    ddpi_serial_mul u_mul2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_a | w_start_b),
        .i_a     (w_mul2_a),
        .i_b     (w_mul2_b),
        .o_stat  (mul2_stat),
        .o_prod  (w_prod2)
    );

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        o_cfg_ready   = 1'b0;
        w_start_a     = 1'b0;
        w_start_b     = 1'b0;
        w_finish      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // A register write goes first, so that a tick always works
                // with settings that are complete; the input item waits.
                s_axis_tready = !i_cfg_valid;
                o_cfg_ready   = 1'b1;
                if (s_axis_tvalid && !i_cfg_valid && (s_axis_tuser[0] == ACT_TICK)) begin
                    w_start_a = 1'b1;
                    n_state   = ST_PHASE_A;
                end
            end
            ST_PHASE_A: begin
                if (!w_units_busy) begin
                    w_start_b = 1'b1;
                    n_state   = ST_PHASE_B;
                end
            end
            ST_PHASE_B: begin
                if (!w_units_busy) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                // Wait for the output register to be free.
                if (!r_m_valid || m_axis_tready) begin
                    w_finish = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_in_accept  = s_axis_tvalid & s_axis_tready;
    assign w_cfg_accept = i_cfg_valid & o_cfg_ready;

    // ------------------------------------------------------------------------
    // Rounding of the products
    // ------------------------------------------------------------------------
    // Position steps are Q54 products rounded half up to Q10.16; the heading
    // step is rounded to ANGLE_BITS, and only its low bits matter because the
    // heading wraps.
    logic [MUL_P_W-1:0]     w_rx;
    logic [MUL_P_W-1:0]     w_ry;
    logic [HEAD_PROD_W-1:0] w_rh;

    always_comb begin
        w_rx = w_prod0 + (MUL_P_W'(1) << (STEP_SH - 1));
        w_ry = w_prod1 + (MUL_P_W'(1) << (STEP_SH - 1));
        w_rh = w_prod2[HEAD_PROD_W-1:0] + (HEAD_PROD_W'(1) << (DH_SH - 1));
    end

    // ------------------------------------------------------------------------
    // Pose update with saturation
    // ------------------------------------------------------------------------
    logic signed [SUM_W-1:0]      w_sum_x;
    logic signed [SUM_W-1:0]      w_sum_y;
    logic                         w_hit_x;
    logic                         w_hit_y;
    logic        [POS_BITS-1:0]   w_new_x;
    logic        [POS_BITS-1:0]   w_new_y;
    logic        [ANGLE_BITS-1:0] w_new_heading;
    logic signed [POS_EXT_W-1:0]  w_ext_x;
    logic signed [POS_EXT_W-1:0]  w_ext_y;
    logic        [HEAD_EXT_W-1:0] w_head_ext;

    always_comb begin
        w_sum_x = SUM_W'($signed(r_pos_x)) + SUM_W'($signed(r_step_x));
        w_sum_y = SUM_W'($signed(r_pos_y)) + SUM_W'($signed(r_step_y));
        // The sum fits when all bits above the position sign agree with it.
        w_hit_x = !((&w_sum_x[SUM_W-1:POS_BITS-1]) || !(|w_sum_x[SUM_W-1:POS_BITS-1]));
        w_hit_y = !((&w_sum_y[SUM_W-1:POS_BITS-1]) || !(|w_sum_y[SUM_W-1:POS_BITS-1]));
        if (w_hit_x) begin
            w_new_x = {w_sum_x[SUM_W-1], {(POS_BITS - 1){~w_sum_x[SUM_W-1]}}};
        end else begin
            w_new_x = w_sum_x[POS_BITS-1:0];
        end
        if (w_hit_y) begin
            w_new_y = {w_sum_y[SUM_W-1], {(POS_BITS - 1){~w_sum_y[SUM_W-1]}}};
        end else begin
            w_new_y = w_sum_y[POS_BITS-1:0];
        end
        w_new_heading = r_heading + r_dh;
        w_ext_x    = POS_EXT_W'($signed(w_new_x));
        w_ext_y    = POS_EXT_W'($signed(w_new_y));
        w_head_ext = HEAD_EXT_W'(w_new_heading) << (HEAD_EXT_W - ANGLE_BITS);
    end

    // ------------------------------------------------------------------------
    // Start value loading
    // ------------------------------------------------------------------------
    // Start positions are clipped to the position range; the start heading is
    // rescaled from a 16-bit angle to ANGLE_BITS.
    logic signed [POS_LD_W-1:0]   w_ld;
    logic                         w_ld_hit;
    logic        [POS_BITS-1:0]   w_ld_pos;
    logic        [HEAD_EXT_W-1:0] w_ld_head;

    always_comb begin
        w_ld     = POS_LD_W'($signed(i_cfg_data));
        w_ld_hit = !((&w_ld[POS_LD_W-1:POS_BITS-1]) || !(|w_ld[POS_LD_W-1:POS_BITS-1]));
        if (w_ld_hit) begin
            w_ld_pos = {w_ld[POS_LD_W-1], {(POS_BITS - 1){~w_ld[POS_LD_W-1]}}};
        end else begin
            w_ld_pos = w_ld[POS_BITS-1:0];
        end
        w_ld_head = HEAD_EXT_W'(i_cfg_data[HEAD_OUT_W-1:0]) << (HEAD_EXT_W - HEAD_OUT_W);
    end

    // ------------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= STEP_TIME_RESET;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            r_cmd_speed <= '0;
            r_cmd_turn  <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (w_cfg_accept) begin
                unique case (i_cfg_index)
                    CFG_STEP_TIME:     r_step_time <= i_cfg_data[STEP_T_W-1:0];
                    CFG_START_X:       r_pos_x     <= w_ld_pos;
                    CFG_START_Y:       r_pos_y     <= w_ld_pos;
                    CFG_START_HEADING: begin
                        r_heading <= w_ld_head[HEAD_EXT_W-1:HEAD_EXT_W-ANGLE_BITS];
                    end
                    default: ;
                endcase
            end

            if (w_in_accept && (s_axis_tuser[0] == ACT_COMMAND)) begin
                r_cmd_speed <= s_axis_tdata[SPEED_W-1:0];
                r_cmd_turn  <= s_axis_tdata[2*SPEED_W-1:SPEED_W];
            end

            if (r_state == ST_ROUND) begin
                r_step_x <= w_rx[STEP_SH+STEP_W-1:STEP_SH];
                r_step_y <= w_ry[STEP_SH+STEP_W-1:STEP_SH];
                r_dh     <= w_rh[HEAD_PROD_W-1:DH_SH];
            end

            // A new result may replace the one taken in the same cycle.
            if (w_finish) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (w_finish) begin
                r_pos_x       <= w_new_x;
                r_pos_y       <= w_new_y;
                r_heading     <= w_new_heading;
                r_out_x       <= w_ext_x[POS_OUT_W-1:0];
                r_out_y       <= w_ext_y[POS_OUT_W-1:0];
                r_out_heading <= w_head_ext[HEAD_EXT_W-1:HEAD_EXT_W-HEAD_OUT_W];
                r_out_speed   <= r_cmd_speed;
                r_out_turn    <= r_cmd_turn;
                r_out_sat     <= w_hit_x | w_hit_y;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_out_turn, r_out_speed, r_out_heading, r_out_y, r_out_x};
    assign m_axis_tuser  = r_out_sat;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `DDPI_ASSERT_NEXT(a_tick_starts_units,
        w_in_accept && (s_axis_tuser[0] == ACT_TICK),
        (r_state == ST_PHASE_A) && cordic_stat.busy && mul0_stat.busy && mul2_stat.busy,
        "tick item did not start the arithmetic units")
    `DDPI_ASSERT_NEXT(a_command_latched,
        w_in_accept && (s_axis_tuser[0] == ACT_COMMAND),
        (r_state == ST_IDLE) && (r_cmd_speed == $past(s_axis_tdata[SPEED_W-1:0])),
        "command item was not latched in one cycle")
    `DDPI_ASSERT_SAME(a_result_from_finish,
        $rose(r_m_valid),
        $past(r_state) == ST_FINISH,
        "result appeared outside the finish step")
    `DDPI_ASSERT_SAME(a_muls_in_step,
        mul0_stat.done && (r_state == ST_PHASE_B),
        mul1_stat.done && mul2_stat.done,
        "second-round multipliers finished out of step")
    `DDPI_ASSERT_SAME(a_cordic_in_round_one,
        cordic_stat.done,
        r_state == ST_PHASE_A,
        "CORDIC finished outside the first round")

endmodule
